/* design/websocket_client_frame_encoder_core_macros.svh */
// Assertion macros for the client frame encoder.
// Each macro checks a property on the rising edge of clk_i, ignored during reset.
`ifndef WEBSOCKET_CLIENT_FRAME_ENCODER_CORE_MACROS_SVH
`define WEBSOCKET_CLIENT_FRAME_ENCODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every checked edge.
`define WSFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// The condition must never be seen at a checked edge.
`define WSFE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define WSFE_ASSERT(lbl, prop, msg)
`define WSFE_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* design/wsfe_pkg.sv */
`timescale 1ns / 1ps

package wsfe_pkg;

  // Operation codes of an input beat.
  localparam logic OpStart = 1'b0;
  localparam logic OpData  = 1'b1;

  // Header constants.
  localparam logic [7:0]  HdrFinText = 8'h81;
  localparam logic [7:0]  HdrMaskBit = 8'h80;
  localparam logic [6:0]  LenExt16   = 7'd126;
  localparam logic [15:0] LenExtMin  = 16'd126;

  // Command queue geometry.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  // Byte positions within a frame header.
  localparam logic [2:0] PosFin   = 3'd0;
  localparam logic [2:0] PosLen   = 3'd1;
  localparam logic [2:0] PosExtHi = 3'd2;
  localparam logic [2:0] PosExtLo = 3'd3;
  localparam logic [2:0] PosKey0  = 3'd4;
  localparam logic [2:0] PosKey3  = 3'd7;

  // Kinds of command passed from the front to the back.
  typedef enum logic [1:0] {
    CmdStart,
    CmdData,
    CmdError
  } cmd_e;

  // One queued command.
  typedef struct packed {
    cmd_e        kind;
    logic [15:0] len;
    logic [31:0] key;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // Key byte at a position; byte 0 sits in bits 31..24.
  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
    logic [7:0] kb;
    unique case (pos)
      2'd0: kb = key[31:24];
      2'd1: kb = key[23:16];
      2'd2: kb = key[15:8];
      2'd3: kb = key[7:0];
      default: kb = key[7:0];
    endcase
    return kb;
  endfunction

endpackage

/* design/wsfe_front.sv */
`timescale 1ns / 1ps

module wsfe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              operation_i,
  input  logic [19:0]       payload_length_i,
  input  logic [31:0]       mask_key_i,
  input  logic [7:0]        data_byte_i,
  input  wsfe_pkg::qstat_t  qstat_i,
  output logic              full_o,
  output logic              cmd_push_o,
  output wsfe_pkg::cmd_t    cmd_o
);

  logic        frame_open_q, frame_open_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [31:0] mask_held_q, mask_held_d;
  logic [1:0]  mask_pos_q, mask_pos_d;
  logic        accept;
  logic        too_long;
  logic        last_byte;

  assign full_o    = qstat_i.full;
  assign accept    = push_i && !qstat_i.full;
  assign too_long  = (payload_length_i[19:16] != 4'd0);
  assign last_byte = (bytes_left_q == 16'd1);

  // Classify the beat, update the frame state and build the command.
  always_comb begin
    frame_open_d = frame_open_q;
    bytes_left_d = bytes_left_q;
    mask_held_d  = mask_held_q;
    mask_pos_d   = mask_pos_q;
    cmd_push_o   = 1'b0;
    cmd_o.kind   = wsfe_pkg::CmdData;
    cmd_o.len    = payload_length_i[15:0];
    cmd_o.key    = mask_key_i;
    cmd_o.data   = data_byte_i ^ wsfe_pkg::key_byte(mask_held_q, mask_pos_q);
    cmd_o.last   = last_byte;
    if (accept) begin
      if (operation_i == wsfe_pkg::OpStart) begin
        cmd_push_o   = 1'b1;
        mask_pos_d   = 2'd0;
        if (too_long) begin
          cmd_o.kind   = wsfe_pkg::CmdError;
          frame_open_d = 1'b0;
          bytes_left_d = 16'd0;
        end else begin
          cmd_o.kind   = wsfe_pkg::CmdStart;
          frame_open_d = (payload_length_i[15:0] != 16'd0);
          bytes_left_d = payload_length_i[15:0];
          mask_held_d  = mask_key_i;
        end
      end else if (frame_open_q) begin
        // A payload byte is queued only while a frame is open; otherwise it is dropped.
        cmd_push_o   = 1'b1;
        mask_pos_d   = mask_pos_q + 2'd1;
        bytes_left_d = bytes_left_q - 16'd1;
        frame_open_d = !last_byte;
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      bytes_left_q <= 16'd0;
      mask_held_q  <= 32'd0;
      mask_pos_q   <= 2'd0;
    end else begin
      frame_open_q <= frame_open_d;
      bytes_left_q <= bytes_left_d;
      mask_held_q  <= mask_held_d;
      mask_pos_q   <= mask_pos_d;
    end
  end

endmodule

/* design/wsfe_cmd_fifo.sv */
`timescale 1ns / 1ps

module wsfe_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wsfe_pkg::cmd_t    cmd_i,
  input  logic              pop_i,
  output wsfe_pkg::cmd_t    head_o,
  output wsfe_pkg::qstat_t  qstat_o
);

  wsfe_pkg::cmd_t                  mem_q [wsfe_pkg::QueueDepth];
  logic [wsfe_pkg::QueueAw-1:0]    wr_ptr_q, wr_ptr_d;
  logic [wsfe_pkg::QueueAw-1:0]    rd_ptr_q, rd_ptr_d;
  logic [wsfe_pkg::QueueAw:0]      count_q, count_d;
  logic                            do_push;
  logic                            do_pop;

  assign qstat_o.empty = (count_q == '0);
  assign qstat_o.full  = (count_q == (wsfe_pkg::QueueAw + 1)'(wsfe_pkg::QueueDepth));
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Command storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* design/wsfe_back.sv */
`timescale 1ns / 1ps

module wsfe_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wsfe_pkg::cmd_t    head_i,
  input  wsfe_pkg::qstat_t  qstat_i,
  output logic              cmd_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        out_byte_o,
  output logic              frame_end_o,
  output logic              too_large_o
);

  logic [2:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       frame_end_q, frame_end_d;
  logic       too_large_q, too_large_d;
  logic       out_ready;
  logic       emit;
  logic       last_beat;
  logic       ext_len;

  assign out_ready = !out_valid_q || pop_i;
  assign emit      = !qstat_i.empty && out_ready;
  assign ext_len   = (head_i.len >= wsfe_pkg::LenExtMin);
  assign cmd_pop_o = emit && last_beat;

  // Expand the head command into the byte for this beat.
  always_comb begin
    out_byte_d  = 8'd0;
    frame_end_d = 1'b0;
    too_large_d = 1'b0;
    last_beat   = 1'b1;
    unique case (head_i.kind)
      wsfe_pkg::CmdStart: begin
        last_beat = (pos_q == wsfe_pkg::PosKey3);
        unique case (pos_q)
          wsfe_pkg::PosFin: out_byte_d = wsfe_pkg::HdrFinText;
          wsfe_pkg::PosLen: begin
            out_byte_d = ext_len ? (wsfe_pkg::HdrMaskBit | {1'b0, wsfe_pkg::LenExt16})
                                 : (wsfe_pkg::HdrMaskBit | {1'b0, head_i.len[6:0]});
          end
          wsfe_pkg::PosExtHi: out_byte_d = head_i.len[15:8];
          wsfe_pkg::PosExtLo: out_byte_d = head_i.len[7:0];
          default: out_byte_d = wsfe_pkg::key_byte(head_i.key, pos_q[1:0]);
        endcase
        frame_end_d = last_beat && (head_i.len == 16'd0);
      end
      wsfe_pkg::CmdData: begin
        out_byte_d  = head_i.data;
        frame_end_d = head_i.last;
      end
      wsfe_pkg::CmdError: begin
        frame_end_d = 1'b1;
        too_large_d = 1'b1;
      end
      default: begin
        frame_end_d = 1'b1;
        too_large_d = 1'b1;
      end
    endcase
  end

  // Header position sequencing; short lengths skip the extended bytes.
  always_comb begin
    pos_d = pos_q;
    if (emit && head_i.kind == wsfe_pkg::CmdStart) begin
      if (last_beat) begin
        pos_d = wsfe_pkg::PosFin;
      end else if (pos_q == wsfe_pkg::PosLen && !ext_len) begin
        pos_d = wsfe_pkg::PosKey0;
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= wsfe_pkg::PosFin;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output beat payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q  <= out_byte_d;
      frame_end_q <= frame_end_d;
      too_large_q <= too_large_d;
    end
  end

  assign empty_o     = !out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;
  assign too_large_o = too_large_q;

endmodule

/* design/websocket_client_frame_encoder_core.sv */
`timescale 1ns / 1ps

// Masked client text frame encoder. A start beat (operation 0) queues a frame
// header: 0x81, the masked length byte, two extended length bytes when the
// length is 126 or more, then the four key bytes. Each payload beat (operation 1)
// yields one masked byte, the frame's final byte carrying frame_end. A length of
// 65536 or more yields a single beat with too_large set; payload beats with no
// frame open are accepted and dropped. A start beat holds the byte sequencer
// for all of its header bytes, while a 4-entry command queue keeps the input
// side accepting one beat per cycle until it fills. Results come out one byte
// per cycle, while pop keeps up, from a single output register.

`include "websocket_client_frame_encoder_core_macros.svh"

module websocket_client_frame_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        operation_i,
  input  logic [19:0] payload_length_i,
  input  logic [31:0] mask_key_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o,
  output logic        too_large_o
);

  wsfe_pkg::cmd_t   cmd_in;
  wsfe_pkg::cmd_t   cmd_head;
  wsfe_pkg::qstat_t qstat;
  logic             cmd_push;
  logic             cmd_pop;

  // Front: accept and classify beats, track the open frame.
  wsfe_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .operation_i      (operation_i),
    .payload_length_i (payload_length_i),
    .mask_key_i       (mask_key_i),
    .data_byte_i      (data_byte_i),
    .qstat_i          (qstat),
    .full_o           (full),
    .cmd_push_o       (cmd_push),
    .cmd_o            (cmd_in)
  );

  // Command queue between front and back.
  wsfe_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .pop_i   (cmd_pop),
    .head_o  (cmd_head),
    .qstat_o (qstat)
  );

  // Back: expand commands into output bytes.
  wsfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (cmd_head),
    .qstat_i     (qstat),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o),
    .too_large_o (too_large_o)
  );

  // The front never queues a command into a full queue.
  `WSFE_ASSERT_NEVER(a_no_push_full, cmd_push && qstat.full, "command pushed into full queue")
  // The back only retires a command that is present.
  `WSFE_ASSERT_NEVER(a_no_pop_empty, cmd_pop && qstat.empty, "command popped from empty queue")
  // An error beat is a lone zero byte that ends the frame.
  `WSFE_ASSERT(a_error_beat, (!empty && too_large_o) |-> (frame_end_o && out_byte_o == 8'd0), "malformed error beat")

endmodule
